@@ sv/scfp_pkg.sv @@
package scfp_pkg;

	localparam int StoreDepth = 64;
	localparam int AddrW = $clog2(StoreDepth);
	localparam int SizeW = AddrW + 1;
	localparam int DefaultMaxPayload = 64;

	localparam logic [7:0] StartByte = 8'h3F;
	localparam logic [7:0] DirByte = 8'h43;

	// Handoff of a frame whose checksum matched.
	typedef struct packed {
		logic             start;
		logic [7:0]       cmd;
		logic [SizeW-1:0] size;
	} frame_t;

endpackage

@@ sv/scfp_store.sv @@
module scfp_store
	import scfp_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [7:0]       rdata
);

	logic [7:0] mem [StoreDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/scfp_parser.sv @@
module scfp_parser
	import scfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = DefaultMaxPayload
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [7:0]       rx_byte,
	output logic             we,
	output logic [AddrW-1:0] waddr,
	output logic [7:0]       wdata,
	output frame_t           frame
);

	localparam int SizeLimit = (MAX_PAYLOAD > StoreDepth) ? StoreDepth : MAX_PAYLOAD;
	localparam logic [8:0] SizeLimitV = 9'(SizeLimit);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_GOT_START,
		PH_SIZE,
		PH_COMMAND,
		PH_PAYLOAD
	} phase_t;

	phase_t           phase_q;
	logic [SizeW-1:0] size_q;
	logic [SizeW-1:0] count_q;
	logic [7:0]       cmd_q;
	logic [7:0]       xor_q;
	logic             accept;
	logic             more;

	assign accept = in_valid && in_ready;
	assign more = count_q < size_q;

	assign we = accept && (phase_q == PH_PAYLOAD) && more;
	assign waddr = count_q[AddrW-1:0];
	assign wdata = rx_byte;

	assign frame.start = accept && (phase_q == PH_PAYLOAD) && !more && (xor_q == rx_byte);
	assign frame.cmd = cmd_q;
	assign frame.size = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			size_q <= '0;
			count_q <= '0;
			cmd_q <= '0;
			xor_q <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					phase_q <= (rx_byte == StartByte) ? PH_GOT_START : PH_HUNT;
				end
				PH_GOT_START: begin
					phase_q <= (rx_byte == DirByte) ? PH_SIZE : PH_HUNT;
				end
				PH_SIZE: begin
					if ({1'b0, rx_byte} > SizeLimitV) begin
						phase_q <= PH_HUNT;
					end else begin
						size_q <= rx_byte[SizeW-1:0];
						count_q <= '0;
						xor_q <= rx_byte;
						phase_q <= PH_COMMAND;
					end
				end
				PH_COMMAND: begin
					cmd_q <= rx_byte;
					xor_q <= xor_q ^ rx_byte;
					phase_q <= PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (more) begin
						xor_q <= xor_q ^ rx_byte;
						count_q <= count_q + 1'b1;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

endmodule

@@ sv/scfp_emitter.sv @@
module scfp_emitter
	import scfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  frame_t           frame,
	output logic             busy,
	output logic             re,
	output logic [AddrW-1:0] raddr,
	input  logic [7:0]       rdata,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       command_code,
	output logic [7:0]       payload_byte,
	output logic [5:0]       byte_index,
	output logic             has_data,
	output logic             last
);

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_FETCH,
		EM_SHOW
	} em_state_t;

	em_state_t        state_q;
	logic [AddrW-1:0] idx_q;
	logic [SizeW-1:0] size_q;
	logic [7:0]       cmd_q;
	logic             data_q;
	logic             is_last;

	assign is_last = !data_q || ({1'b0, idx_q} == size_q - 1'b1);

	assign busy = state_q != EM_IDLE;
	assign re = state_q == EM_FETCH;
	assign raddr = idx_q;

	assign out_valid = state_q == EM_SHOW;
	assign command_code = cmd_q;
	// The read register holds still in the show state since no read is issued there.
	assign payload_byte = data_q ? rdata : 8'h00;
	assign byte_index = 6'(idx_q);
	assign has_data = data_q;
	assign last = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			idx_q <= '0;
			size_q <= '0;
			cmd_q <= '0;
			data_q <= 1'b0;
		end else begin
			unique case (state_q)
				EM_IDLE: begin
					if (frame.start) begin
						cmd_q <= frame.cmd;
						size_q <= frame.size;
						idx_q <= '0;
						data_q <= frame.size != '0;
						state_q <= (frame.size != '0) ? EM_FETCH : EM_SHOW;
					end
				end
				EM_FETCH: begin
					state_q <= EM_SHOW;
				end
				EM_SHOW: begin
					if (out_ready) begin
						if (is_last) begin
							state_q <= EM_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= EM_FETCH;
						end
					end
				end
				default: begin
					state_q <= EM_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/serial_command_frame_parser_unit.sv @@
// Serial command frame parser. Received bytes enter one beat at a time and are
// checked for frames of the form '?', 'C', size, command, payload, checksum,
// where the checksum is the XOR of size, command and payload. While a frame is
// being received its payload bytes are written into a 64-entry payload memory.
// After a good checksum the stored payload is played back in order, one result
// beat per byte, tagged with the command code, with the final beat marked; an
// empty frame gives one beat with has_data low. Each played-back byte is first
// read from the memory and then shown as an output beat, and in_ready stays low
// until the last result beat of the frame is taken. Sizes above MAX_PAYLOAD
// (capped at 64) and bad checksums produce nothing.
module serial_command_frame_parser_unit
	import scfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = DefaultMaxPayload
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] command_code,
	output logic [7:0] payload_byte,
	output logic [5:0] byte_index,
	output logic       has_data,
	output logic       last
);

	logic             we;
	logic [AddrW-1:0] waddr;
	logic [7:0]       wdata;
	logic             re;
	logic [AddrW-1:0] raddr;
	logic [7:0]       rdata;
	logic             busy;
	frame_t           frame;

	assign in_ready = !busy;

	scfp_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.frame    (frame)
	);

	scfp_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	scfp_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.busy         (busy),
		.re           (re),
		.raddr        (raddr),
		.rdata        (rdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.command_code (command_code),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.has_data     (has_data),
		.last         (last)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import scfp_pkg::*;

	localparam int SizeLimit = (DefaultMaxPayload > StoreDepth) ? StoreDepth : DefaultMaxPayload;
	localparam int CycleLimit = 200000;
	localparam int RandomBytes = 220;

	typedef enum logic [2:0] {
		HUNT,
		GOT_START,
		GOT_DIR,
		GOT_SIZE,
		IN_PAYLOAD
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] cmd;
		logic [7:0] data;
		logic [5:0] index;
		logic       has_data;
		logic       last;
	} beat_t;

	// Tracks the frame parser byte by byte and holds the result beats it owes.
	class frame_scoreboard;
		parse_phase_t     phase = HUNT;
		logic [SizeW-1:0] frame_size = '0;
		logic [SizeW-1:0] frame_count = '0;
		logic [7:0]       frame_cmd = '0;
		logic [7:0]       frame_xor = '0;
		logic [7:0]       store [StoreDepth];
		beat_t            owed_beats [$];
		int               errors = 0;
		int               checked = 0;
		int               good_frames = 0;

		task report_mismatch(input string what);
			$display("MISMATCH: %s", what);
			errors++;
		endtask

		function void note_rx_byte(input logic [7:0] b);
			beat_t e;
			int i;
			case (phase)
				HUNT: begin
					phase = (b == StartByte) ? GOT_START : HUNT;
				end
				GOT_START: begin
					phase = (b == DirByte) ? GOT_DIR : HUNT;
				end
				GOT_DIR: begin
					if (int'(b) > SizeLimit) begin
						phase = HUNT;
					end else begin
						frame_size = b[SizeW-1:0];
						frame_count = '0;
						frame_xor = b;
						phase = GOT_SIZE;
					end
				end
				GOT_SIZE: begin
					frame_cmd = b;
					frame_xor ^= b;
					phase = IN_PAYLOAD;
				end
				IN_PAYLOAD: begin
					if (frame_count < frame_size) begin
						frame_xor ^= b;
						store[frame_count[AddrW-1:0]] = b;
						frame_count++;
					end else begin
						if (frame_xor == b) begin
							good_frames++;
							if (frame_size == 0) begin
								e = '{frame_cmd, 8'h00, 6'd0, 1'b0, 1'b1};
								owed_beats.push_back(e);
							end else begin
								for (i = 0; i < int'(frame_size); i++) begin
									e.cmd = frame_cmd;
									e.data = store[i];
									e.index = i[5:0];
									e.has_data = 1'b1;
									e.last = (i == int'(frame_size) - 1);
									owed_beats.push_back(e);
								end
							end
						end
						phase = HUNT;
					end
				end
				default: begin
					phase = HUNT;
				end
			endcase
		endfunction

		task check_beat(input beat_t got);
			beat_t e;
			checked++;
			if (owed_beats.size() == 0) begin
				report_mismatch($sformatf("result beat cmd %h data %h index %0d with none owed",
					got.cmd, got.data, got.index));
			end else begin
				e = owed_beats.pop_front();
				if (got.cmd !== e.cmd)
					report_mismatch($sformatf("command_code %h, want %h", got.cmd, e.cmd));
				if (got.data !== e.data)
					report_mismatch($sformatf("payload_byte %h, want %h", got.data, e.data));
				if (got.index !== e.index)
					report_mismatch($sformatf("byte_index %0d, want %0d", got.index, e.index));
				if (got.has_data !== e.has_data)
					report_mismatch($sformatf("has_data %b, want %b", got.has_data, e.has_data));
				if (got.last !== e.last)
					report_mismatch($sformatf("last %b, want %b", got.last, e.last));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] command_code;
	logic [7:0] payload_byte;
	logic [5:0] byte_index;
	logic       has_data;
	logic       last;

	frame_scoreboard sb = new();
	int  cycle_count = 0;
	int  rx_count = 0;
	int  frames_sent = 0;
	bit  quiet = 1'b0;

	serial_command_frame_parser_unit #(
		.MAX_PAYLOAD(DefaultMaxPayload)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.command_code(command_code),
		.payload_byte(payload_byte),
		.byte_index(byte_index),
		.has_data(has_data),
		.last(last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat({command_code, payload_byte, byte_index, has_data, last});
	end

	// Result side stalls in short random bursts until the quiet tail of the run.
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				stall_left = $urandom_range(1, 7) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sb.note_rx_byte(b);
		rx_count++;
		@(negedge clk);
	endtask

	task automatic send_frame(input int n, input logic [7:0] cmd, input logic [7:0] chk_flip);
		logic [7:0] x;
		logic [7:0] d;
		int i;
		frames_sent++;
		send_byte(StartByte);
		send_byte(DirByte);
		send_byte(n[7:0]);
		x = n[7:0];
		send_byte(cmd);
		x ^= cmd;
		for (i = 0; i < n; i++) begin
			d = 8'($urandom_range(0, 255));
			x ^= d;
			send_byte(d);
		end
		send_byte(x ^ chk_flip);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.owed_beats.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int base;
		int frame_no;
		int n;
		int kind;
		logic [7:0] b;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Noise at both extremes, then an empty frame.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(0, 8'hFF, 8'h00);
		// A repeated start byte: the second one is dropped as a bad direction byte.
		send_byte(StartByte);
		send_byte(StartByte);
		send_byte(StartByte);
		send_byte(DirByte);
		send_byte(8'd1);
		send_byte(8'h80);
		send_byte(8'h55);
		send_byte(8'h01 ^ 8'h80 ^ 8'h55);
		// Oversized frame, then a checksum that does not match.
		send_byte(StartByte);
		send_byte(DirByte);
		send_byte(8'hFF);
		send_frame(1, 8'h10, 8'h5A);

		wait_drained();

		base = rx_count;
		frame_no = 0;
		while (rx_count - base < RandomBytes) begin
			if (rx_count - base > RandomBytes - 40)
				quiet = 1'b1;
			if (frame_no == 2)
				n = SizeLimit;
			else if ($urandom_range(0, 15) == 0)
				n = $urandom_range(9, SizeLimit);
			else
				n = $urandom_range(0, 8);
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					send_byte(8'($urandom_range(0, 255)));
				end
				1: begin
					case ($urandom_range(0, 2))
						0: begin
							b = 8'($urandom_range(0, 255));
							if (b == DirByte)
								b = ~b;
							send_byte(StartByte);
							send_byte(b);
						end
						1: begin
							send_byte(StartByte);
							send_byte(DirByte);
							send_byte(8'($urandom_range(SizeLimit + 1, 255)));
						end
						default: begin
							send_frame(n, 8'($urandom_range(0, 255)),
								8'($urandom_range(1, 255)));
						end
					endcase
				end
				default: begin
					send_frame(n, 8'($urandom_range(0, 255)), 8'h00);
				end
			endcase
			frame_no++;
			if (frame_no == 6)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(negedge clk);

		$display("Sent %0d rx beats with %0d framed attempts; %0d frames passed the checksum.",
			rx_count, frames_sent, sb.good_frames);
		$display("Checked %0d result beats in %0d cycles.", sb.checked, cycle_count);
		if (sb.errors == 0 && sb.owed_beats.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/scfp_pkg.sv
sv/scfp_store.sv
sv/scfp_parser.sv
sv/scfp_emitter.sv
sv/serial_command_frame_parser_unit.sv
tb/tb.sv
